// ===== rtl/mfp_pkg.sv =====
// Shared types and constants for the meter frame parser.
// Holds frame geometry, header characters, register indexes and the result word.
// No dependencies.
package mfp_pkg;

   // Frame geometry
   localparam int SHORT_FRAME_LEN = 55;
   localparam int LONG_FRAME_LEN  = 67;
   localparam int TAIL_LEN        = 43;

   localparam logic [6:0] SHORT_LEN = 7'(SHORT_FRAME_LEN);
   localparam logic [6:0] LONG_LEN  = 7'(LONG_FRAME_LEN);

   // First byte count at which the head checksum byte is reached
   localparam logic signed [8:0] SHORT_HEAD_END = 9'(SHORT_FRAME_LEN - TAIL_LEN);
   localparam logic signed [8:0] LONG_HEAD_END  = 9'(LONG_FRAME_LEN - TAIL_LEN);

   // Byte count value just past the status byte
   localparam logic [6:0] STATUS_COUNT = 7'd9;

   // Scrambler base key and header characters
   localparam logic [7:0] KEY_BASE = 8'h29;
   localparam logic [7:0] CHAR_G   = 8'h47;
   localparam logic [7:0] CHAR_P   = 8'h50;
   localparam logic [7:0] CHAR_S   = 8'h53;
   localparam logic [3:0] STATUS_MAX = 4'd2;

   // Trip event codes
   localparam logic [1:0] TRIP_NONE  = 2'd0;
   localparam logic [1:0] TRIP_START = 2'd1;
   localparam logic [1:0] TRIP_STOP  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_DATE_DAY   = 2'd0;
   localparam logic [1:0] CSR_DATE_MONTH = 2'd1;

   // Parser phases, one-hot
   typedef enum logic [6:0] {
      PH_G      = 7'b0000001,
      PH_P      = 7'b0000010,
      PH_S      = 7'b0000100,
      PH_STATUS = 7'b0001000,
      PH_HEAD   = 7'b0010000,
      PH_TAIL   = 7'b0100000,
      PH_PAD    = 7'b1000000
   } phase_type;

   // One result word
   typedef struct packed {
      logic [7:0] plain_byte;
      logic       stored;
      logic [6:0] byte_position;
      logic [1:0] trip_event;
      logic       long_frame;
      logic       head_check_fail;
      logic       frame_done;
      logic       tail_check_ok;
   } result_type;

endpackage

// ===== rtl/meter_frame_parser_unit.sv =====
// Meter frame parser: input register, parser decode and result register.
// An accepted input word is held in the input register, and its result word in the result register.
// Throughput: one word per cycle while rsp_tready does not hold the result register.
// Reset: synchronous, active high; clears the date registers, parser state
// and both valid flags. No clearing pass.
// Depends on mfp_pkg, mfp_key and mfp_parser.
module meter_frame_parser_unit
   import mfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_byte
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] plain_byte, [14:8] byte_position, [15] zero
   output logic [5:0]  rsp_tuser,   // [0] stored, [2:1] trip_event, [3] long_frame,
                                    // [4] head_check_fail, [5] tail_check_ok
   output logic        rsp_tlast,   // frame_done
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       out_free;
   logic       step;
   logic [7:0] key;
   result_type result;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || step;

   mfp_key u_key (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .key       (key)
   );

   mfp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .raw_byte (in_byte_ff),
      .key      (key),
      .result   (result)
   );

   // Input register: hold the word until the parser takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Result register: load on parser step, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.byte_position, out_ff.plain_byte};
   assign rsp_tuser  = {out_ff.tail_check_ok, out_ff.head_check_fail, out_ff.long_frame,
                        out_ff.trip_event, out_ff.stored};
   assign rsp_tlast  = out_ff.frame_done;

endmodule

// ===== rtl/mfp_key.sv =====
// Date registers and descrambling key for the meter frame parser.
// Depends on mfp_pkg.
module mfp_key
   import mfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_data,
   output logic [7:0] key
);

   logic [4:0] day_ff;
   logic [4:0] day_in;
   logic [3:0] month_ff;
   logic [3:0] month_in;

   // Decode register writes
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DATE_DAY:   day_in   = csr_data;
            CSR_DATE_MONTH: month_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= '0;
         month_ff <= '0;
      end else begin
         day_ff   <= day_in;
         month_ff <= month_in;
      end
   end

   // Only day/8 enters the key
   assign key = KEY_BASE ^ {6'd0, day_ff[4:3]} ^ {4'd0, month_ff};

endmodule

// ===== rtl/mfp_parser.sv =====
// Frame parser state and per-word decode for the meter frame parser.
// Depends on mfp_pkg.
module mfp_parser
   import mfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] raw_byte,
   input  logic [7:0] key,
   output result_type result
);

   phase_type  phase_ff, phase_in;
   logic [6:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic       long_ff, long_in;
   logic [1:0] prev_ff, prev_in;

   logic [7:0] ch;
   logic [6:0] count_inc;
   logic [7:0] sum_add;
   logic [7:0] expect_char;
   logic [3:0] status;
   logic [6:0] frame_len;
   logic signed [8:0] head_end;
   logic       stored, head_fail, done, tail_ok;
   logic [6:0] pos;
   logic [1:0] trip;

   assign ch        = raw_byte ^ key;
   assign count_inc = count_ff + 7'd1;
   assign sum_add   = sum_ff + ch;
   assign status    = ch[3:0];
   assign frame_len = long_ff ? LONG_LEN : SHORT_LEN;
   assign head_end  = long_ff ? LONG_HEAD_END : SHORT_HEAD_END;
   assign expect_char = (phase_ff == PH_P) ? CHAR_P : CHAR_S;

   // Decode one word against the current phase
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      long_in   = long_ff;
      prev_in   = prev_ff;
      stored    = 1'b0;
      pos       = '0;
      trip      = TRIP_NONE;
      head_fail = 1'b0;
      done      = 1'b0;
      tail_ok   = 1'b0;
      unique case (phase_ff)
         PH_G: begin
            if (ch == CHAR_G) begin
               stored   = 1'b1;
               count_in = 7'd1;
               sum_in   = ch;
               phase_in = PH_P;
            end
         end
         PH_P, PH_S: begin
            if (ch == expect_char) begin
               stored   = 1'b1;
               pos      = count_ff;
               count_in = count_inc;
               sum_in   = sum_add;
               phase_in = (phase_ff == PH_P) ? PH_S : PH_STATUS;
            end else begin
               count_in = '0;
               phase_in = PH_G;
            end
         end
         PH_STATUS: begin
            pos      = count_ff;
            count_in = count_inc;
            if (count_inc != STATUS_COUNT) begin
               stored = 1'b1;
               sum_in = sum_add;
            end else if (status > STATUS_MAX) begin
               // Drop frame on bad status
               pos      = '0;
               count_in = '0;
               phase_in = PH_G;
            end else begin
               stored  = 1'b1;
               sum_in  = sum_add;
               long_in = (status != 4'd0);
               if (status == 4'd0 && prev_ff != 2'd0) begin
                  trip = TRIP_STOP;
               end else if (status != 4'd0 && prev_ff == 2'd0) begin
                  trip = TRIP_START;
               end
               prev_in  = status[1:0];
               phase_in = PH_HEAD;
            end
         end
         PH_HEAD: begin
            pos      = count_ff;
            count_in = count_inc;
            if ($signed({2'b00, count_inc}) >= head_end) begin
               if (sum_ff == ch) begin
                  stored   = 1'b1;
                  sum_in   = '0;
                  phase_in = PH_TAIL;
               end else begin
                  pos       = '0;
                  head_fail = 1'b1;
                  count_in  = '0;
                  phase_in  = PH_G;
               end
            end else begin
               stored = 1'b1;
               sum_in = sum_add;
            end
         end
         PH_TAIL: begin
            if (count_ff < frame_len) begin
               stored   = 1'b1;
               pos      = count_ff;
               count_in = count_inc;
               sum_in   = (count_inc == frame_len) ? (sum_ff ^ ch) : sum_add;
            end else begin
               phase_in = PH_PAD;
            end
         end
         PH_PAD: begin
            done     = 1'b1;
            tail_ok  = (sum_ff == 8'd0);
            count_in = '0;
            phase_in = PH_G;
         end
         default: begin
            count_in = '0;
            phase_in = PH_G;
         end
      endcase
   end

   // Advance state on each processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_G;
         count_ff <= '0;
         sum_ff   <= '0;
         long_ff  <= 1'b0;
         prev_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         long_ff  <= long_in;
         prev_ff  <= prev_in;
      end
   end

   assign result.plain_byte      = ch;
   assign result.stored          = stored;
   assign result.byte_position   = pos;
   assign result.trip_event      = trip;
   assign result.long_frame      = long_in;
   assign result.head_check_fail = head_fail;
   assign result.frame_done      = done;
   assign result.tail_check_ok   = tail_ok;

endmodule
